// ===== sv/wsfr_pkg.sv =====
// Shared types and constants for the WebSocket frame receiver.
package wsfr_pkg;

   localparam logic [0:0] OP_DATA    = 1'b0;
   localparam logic [0:0] OP_RESTART = 1'b1;

   localparam logic [1:0] KIND_MSG       = 2'd0;
   localparam logic [1:0] KIND_PING      = 2'd1;
   localparam logic [1:0] KIND_CONNECTED = 2'd2;
   localparam logic [1:0] KIND_CLOSED    = 2'd3;

   localparam logic [2:0] PH_HANDSHAKE = 3'd0;
   localparam logic [2:0] PH_BYTE0     = 3'd1;
   localparam logic [2:0] PH_BYTE1     = 3'd2;
   localparam logic [2:0] PH_EXTLEN    = 3'd3;
   localparam logic [2:0] PH_MASK      = 3'd4;
   localparam logic [2:0] PH_PAYLOAD   = 3'd5;
   localparam logic [2:0] PH_CLOSED    = 3'd6;

   localparam logic [3:0] OPC_CONT  = 4'h0;
   localparam logic [3:0] OPC_TEXT  = 4'h1;
   localparam logic [3:0] OPC_CLOSE = 4'h8;
   localparam logic [3:0] OPC_PING  = 4'h9;

   localparam logic [6:0] LEN_EXT16 = 7'd126;
   localparam logic [6:0] LEN_EXT64 = 7'd127;

   localparam logic [39:0] STATUS_PATTERN = 40'h20_31_30_31_20;  // " 101 "
   localparam logic [31:0] TERM_PATTERN   = 32'h0D_0A_0D_0A;     // CRLFCRLF
   localparam logic [15:0] LIMIT_RESET    = 16'd8192;

   typedef struct packed {
      logic [0:0] operation;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic       has_data;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic [2:0]  phase;
      logic [15:0] handshake_count;
      logic [39:0] recent_bytes;
      logic        saw_status_101;
      logic        frame_final;
      logic [3:0]  frame_opcode;
      logic        frame_masked;
      logic [15:0] payload_length;
      logic [15:0] payload_count;
      logic [31:0] mask_key;
      logic [2:0]  header_index;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_HANDSHAKE,
      handshake_count: 16'd0,
      recent_bytes:    40'd0,
      saw_status_101:  1'b0,
      frame_final:     1'b0,
      frame_opcode:    4'd0,
      frame_masked:    1'b0,
      payload_length:  16'd0,
      payload_count:   16'd0,
      mask_key:        32'd0,
      header_index:    3'd0
   };

endpackage

// ===== sv/websocket_frame_receiver_core.sv =====
// WebSocket receive core: handshake scan, frame header parse and payload unmask.
// A byte's result is loaded into the result register at the edge that accepts the byte.
// Throughput: one byte per cycle; the parse state updates in a single pass per byte.
// The result register frees in the same cycle it is taken, so input stalls only
// while a result waits under rsp_stall.
// Reset (synchronous, active high) returns to handshake scan, limit 8192, no result.
module websocket_frame_receiver_core import wsfr_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   // handshake limit register write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   state_type   state_ff;
   state_type   state_in;
   logic [15:0] limit_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   logic        emit;
   rsp_type     step_rsp;
   logic        req_take;
   logic        rsp_take;

   // Hold input only while a finished result is blocked downstream.
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   wsfr_step u_step (
      .cur_state (state_ff),
      .limit     (limit_ff),
      .req       (req_data),
      .nxt_state (state_in),
      .emit      (emit),
      .rsp       (step_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_RESET;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) limit_ff <= csr_data;
         // Advance the parse state on every accepted byte.
         if (req_take) state_ff <= state_in;
         // Load a new result, or drop the one just taken.
         if (req_take && emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_take) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && emit) rsp_data_ff <= step_rsp;
   end

endmodule

// ===== sv/wsfr_step.sv =====
// Next-state and result logic for one received byte.
module wsfr_step import wsfr_pkg::*; (
   input  state_type   cur_state,
   input  logic [15:0] limit,
   input  req_type     req,
   output state_type   nxt_state,
   output logic        emit,
   output rsp_type     rsp
);

   state_type   nxt;
   logic        do_after;
   logic        do_hdr;
   logic        do_close;
   logic [39:0] shifted;
   logic [6:0]  len7;
   logic [7:0]  key_byte;
   logic        is_msg;

   always_comb begin
      nxt      = cur_state;
      emit     = 1'b0;
      rsp      = '0;
      do_after = 1'b0;
      do_hdr   = 1'b0;
      do_close = 1'b0;
      shifted  = {cur_state.recent_bytes[31:0], req.data_byte};
      len7     = req.data_byte[6:0];
      key_byte = 8'd0;
      is_msg   = cur_state.frame_final &&
                 (cur_state.frame_opcode inside {OPC_CONT, OPC_TEXT});

      case (cur_state.phase)
         PH_HANDSHAKE: begin
            if (cur_state.handshake_count >= limit) begin
               do_close = 1'b1;
            end else begin
               nxt.handshake_count = cur_state.handshake_count + 16'd1;
               nxt.recent_bytes    = shifted;
               if (shifted == STATUS_PATTERN) nxt.saw_status_101 = 1'b1;
               if (shifted[31:0] == TERM_PATTERN) begin
                  if (!nxt.saw_status_101) begin
                     do_close = 1'b1;
                  end else begin
                     nxt.phase           = PH_BYTE0;
                     nxt.recent_bytes    = '0;
                     nxt.handshake_count = '0;
                     emit                = 1'b1;
                     rsp.kind            = KIND_CONNECTED;
                  end
               end
            end
         end
         PH_BYTE0: begin
            nxt.frame_final  = req.data_byte[7];
            nxt.frame_opcode = req.data_byte[3:0];
            nxt.phase        = PH_BYTE1;
         end
         PH_BYTE1: begin
            nxt.frame_masked = req.data_byte[7];
            if (len7 == LEN_EXT64) begin
               do_close = 1'b1;
            end else if (len7 == LEN_EXT16) begin
               nxt.payload_length = '0;
               nxt.header_index   = '0;
               nxt.phase          = PH_EXTLEN;
            end else begin
               nxt.payload_length = {9'd0, len7};
               do_after           = 1'b1;
            end
         end
         PH_EXTLEN: begin
            nxt.payload_length = {cur_state.payload_length[7:0], req.data_byte};
            nxt.header_index   = cur_state.header_index + 3'd1;
            if (nxt.header_index >= 3'd2) do_after = 1'b1;
         end
         PH_MASK: begin
            nxt.mask_key     = {cur_state.mask_key[23:0], req.data_byte};
            nxt.header_index = cur_state.header_index + 3'd1;
            if (nxt.header_index >= 3'd4) do_hdr = 1'b1;
         end
         PH_PAYLOAD: begin
            case (cur_state.payload_count[1:0])
               2'd0:    key_byte = cur_state.mask_key[31:24];
               2'd1:    key_byte = cur_state.mask_key[23:16];
               2'd2:    key_byte = cur_state.mask_key[15:8];
               default: key_byte = cur_state.mask_key[7:0];
            endcase
            nxt.payload_count = cur_state.payload_count + 16'd1;
            rsp.payload_byte  = req.data_byte ^
                                (cur_state.frame_masked ? key_byte : 8'd0);
            rsp.has_data      = 1'b1;
            rsp.last          = (nxt.payload_count >= cur_state.payload_length);
            if (rsp.last) nxt.phase = PH_BYTE0;
            if (cur_state.frame_opcode == OPC_CLOSE) begin
               do_close = rsp.last;
            end else if (cur_state.frame_opcode == OPC_PING) begin
               emit     = 1'b1;
               rsp.kind = KIND_PING;
            end else if (is_msg) begin
               emit     = 1'b1;
               rsp.kind = KIND_MSG;
            end
         end
         default: begin
         end
      endcase

      // Length known: take the mask key next, or finish the header.
      if (do_after) begin
         if (nxt.frame_masked) begin
            nxt.header_index = '0;
            nxt.mask_key     = '0;
            nxt.phase        = PH_MASK;
         end else begin
            do_hdr = 1'b1;
         end
      end

      // Header done: enter payload, or report an empty frame right away.
      if (do_hdr) begin
         nxt.payload_count = '0;
         if (nxt.payload_length != 16'd0) begin
            nxt.phase = PH_PAYLOAD;
         end else begin
            nxt.phase = PH_BYTE0;
            if (nxt.frame_opcode == OPC_CLOSE) begin
               do_close = 1'b1;
            end else if (nxt.frame_opcode == OPC_PING) begin
               emit     = 1'b1;
               rsp.kind = KIND_PING;
               rsp.last = 1'b1;
            end else if (is_msg) begin
               emit     = 1'b1;
               rsp.kind = KIND_MSG;
               rsp.last = 1'b1;
            end
         end
      end

      if (do_close) begin
         nxt.phase = PH_CLOSED;
         emit      = 1'b1;
         rsp       = '0;
         rsp.kind  = KIND_CLOSED;
      end

      if (req.operation == OP_RESTART) begin
         nxt  = STATE_RESET;
         emit = 1'b0;
         rsp  = '0;
      end

      nxt_state = nxt;
   end

endmodule

// ===== dv/tb_websocket_frame_receiver_core.sv =====
// Self-checking testbench for the WebSocket frame receiver core.
module tb_websocket_frame_receiver_core;
   import wsfr_pkg::*;

   localparam int unsigned RANDOM_ITEMS = 1200;
   localparam int unsigned CYCLE_LIMIT  = 600000;
   localparam logic [7:0]  CR = 8'h0D;
   localparam logic [7:0]  LF = 8'h0A;

   logic        clock     = 1'b0;
   logic        reset     = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   req_type     req_data  = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   rsp_type     rsp_data;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_data  = '0;

   // Parser state as the testbench models it, plus the limit register shadow.
   state_type   link;
   logic [15:0] limit_setting;
   rsp_type     expected_events[$];

   int unsigned req_gap_max = 15;
   int unsigned rsp_gap_max = 15;
   int unsigned hold_cycles = 0;
   int unsigned rsp_pause_left = 0;
   int unsigned sent_items = 0;
   int unsigned mismatches = 0;
   int unsigned cycle_count = 0;

   websocket_frame_receiver_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Expected-result model
   // ---------------------------------------------------------------------------------------

   function automatic void post_event(input logic [1:0] kind, input logic [7:0] b,
                                      input logic has, input logic lst);
      rsp_type r;
      r.kind         = kind;
      r.payload_byte = b;
      r.has_data     = has;
      r.last         = lst;
      expected_events = {expected_events, r};
   endfunction

   // Drop the link: every later data byte is ignored until a restart.
   function automatic void close_link();
      link.phase = PH_CLOSED;
      post_event(KIND_CLOSED, 8'h00, 1'b0, 1'b0);
   endfunction

   // Only final text or continuation frames carry message bytes out.
   function automatic logic delivers_message();
      return link.frame_final && (link.frame_opcode == OPC_CONT || link.frame_opcode == OPC_TEXT);
   endfunction

   // Header fully parsed: go to payload, or finish an empty frame right here.
   function automatic void finish_header();
      link.payload_count = '0;
      if (link.payload_length != 16'd0) begin
         link.phase = PH_PAYLOAD;
      end else begin
         link.phase = PH_BYTE0;
         if (link.frame_opcode == OPC_CLOSE)
            close_link();
         else if (link.frame_opcode == OPC_PING)
            post_event(KIND_PING, 8'h00, 1'b0, 1'b1);
         else if (delivers_message())
            post_event(KIND_MSG, 8'h00, 1'b0, 1'b1);
      end
   endfunction

   function automatic void length_complete();
      if (link.frame_masked) begin
         link.header_index = '0;
         link.mask_key     = '0;
         link.phase        = PH_MASK;
      end else begin
         finish_header();
      end
   endfunction

   // Advance the model by one accepted transaction and queue what it should produce.
   function automatic void advance_parser(input logic [0:0] op, input logic [7:0] b);
      logic [7:0] plain;
      logic       lst;
      if (op == OP_RESTART) begin
         link = STATE_RESET;
         return;
      end
      case (link.phase)
         PH_HANDSHAKE: begin
            // limit is checked before the byte is counted
            if (link.handshake_count >= limit_setting) begin
               close_link();
            end else begin
               link.handshake_count = link.handshake_count + 16'd1;
               link.recent_bytes    = {link.recent_bytes[31:0], b};
               if (link.recent_bytes == STATUS_PATTERN)
                  link.saw_status_101 = 1'b1;
               if (link.recent_bytes[31:0] == TERM_PATTERN) begin
                  if (!link.saw_status_101) begin
                     close_link();
                  end else begin
                     link.phase           = PH_BYTE0;
                     link.recent_bytes    = '0;
                     link.handshake_count = '0;
                     post_event(KIND_CONNECTED, 8'h00, 1'b0, 1'b0);
                  end
               end
            end
         end
         PH_BYTE0: begin
            link.frame_final  = b[7];
            link.frame_opcode = b[3:0];
            link.phase        = PH_BYTE1;
         end
         PH_BYTE1: begin
            link.frame_masked = b[7];
            if (b[6:0] == LEN_EXT64) begin
               close_link();
            end else if (b[6:0] == LEN_EXT16) begin
               link.payload_length = '0;
               link.header_index   = '0;
               link.phase          = PH_EXTLEN;
            end else begin
               link.payload_length = {9'd0, b[6:0]};
               length_complete();
            end
         end
         PH_EXTLEN: begin
            link.payload_length = {link.payload_length[7:0], b};
            link.header_index   = link.header_index + 3'd1;
            if (link.header_index >= 3'd2)
               length_complete();
         end
         PH_MASK: begin
            link.mask_key     = {link.mask_key[23:0], b};
            link.header_index = link.header_index + 3'd1;
            if (link.header_index >= 3'd4)
               finish_header();
         end
         PH_PAYLOAD: begin
            // key byte rotates with the payload position, first key byte on byte 0
            plain = b;
            if (link.frame_masked)
               plain = b ^ link.mask_key[8 * (3 - int'(link.payload_count[1:0])) +: 8];
            link.payload_count = link.payload_count + 16'd1;
            lst = (link.payload_count >= link.payload_length);
            if (lst)
               link.phase = PH_BYTE0;
            if (link.frame_opcode == OPC_CLOSE) begin
               if (lst)
                  close_link();
            end else if (link.frame_opcode == OPC_PING) begin
               post_event(KIND_PING, plain, 1'b1, lst);
            end else if (delivers_message()) begin
               post_event(KIND_MSG, plain, 1'b1, lst);
            end
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------
   // Result side: random stall per result, plus a long hold-off on request
   // ---------------------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall      <= 1'b0;
         rsp_pause_left = 0;
      end else if (hold_cycles != 0) begin
         // hold the result channel so the block backs up into its input
         rsp_stall   <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else if (rsp_valid && !rsp_stall) begin
         // a transaction moved this edge: draw the pause before the next one
         rsp_pause_left = $urandom_range(0, rsp_gap_max);
         rsp_stall      <= (rsp_pause_left != 0);
      end else if (rsp_pause_left != 0) begin
         rsp_pause_left = rsp_pause_left - 1;
         rsp_stall      <= (rsp_pause_left != 0);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare every result transaction against the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_events.size() == 0) begin
            $error("unexpected result: kind %0d byte %02h has_data %0d last %0d",
                   rsp_data.kind, rsp_data.payload_byte, rsp_data.has_data, rsp_data.last);
            mismatches++;
         end else begin
            want = expected_events.pop_front();
            if (rsp_data.kind !== want.kind) begin
               $error("kind: expected %0d, got %0d", want.kind, rsp_data.kind);
               mismatches++;
            end
            if (rsp_data.payload_byte !== want.payload_byte) begin
               $error("payload_byte: expected %02h, got %02h",
                      want.payload_byte, rsp_data.payload_byte);
               mismatches++;
            end
            if (rsp_data.has_data !== want.has_data) begin
               $error("has_data: expected %0d, got %0d", want.has_data, rsp_data.has_data);
               mismatches++;
            end
            if (rsp_data.last !== want.last) begin
               $error("last: expected %0d, got %0d", want.last, rsp_data.last);
               mismatches++;
            end
         end
      end
   end

   // Watchdog: a run that passes CYCLE_LIMIT is ended and reported as failed.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Input side
   // ---------------------------------------------------------------------------------------

   // Offer one transaction after a random gap; return at the edge that accepts it.
   task automatic send_byte(input logic [0:0] op, input logic [7:0] b);
      int unsigned gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req_type'({op, b});
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
      advance_parser(op, b);
   endtask

   task automatic send_data(input logic [7:0] b);
      send_byte(OP_DATA, b);
   endtask

   task automatic send_restart();
      send_byte(OP_RESTART, 8'($urandom));
   endtask

   task automatic send_string(input string s);
      for (int i = 0; i < s.len(); i++)
         send_data(s[i]);
   endtask

   task automatic send_crlf();
      send_data(CR);
      send_data(LF);
   endtask

   // Drop valid and let every outstanding result drain, then allow the pipeline to settle.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_events.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid     <= 1'b0;
      limit_setting = value;
   endtask

   // Status line, random header filler sprinkled with pattern characters, blank line.
   task automatic send_upgrade_reply(input bit with_status);
      int unsigned filler;
      logic [7:0]  c;
      filler = $urandom_range(0, 12);
      if (with_status) begin
         if ($urandom_range(0, 1) != 0)
            send_string("HTTP/1.1 101 OK");
         else
            send_string(" 101 ");
      end else begin
         if ($urandom_range(0, 1) != 0)
            send_string("HTTP/1.1 200 OK");
         else
            send_string("HTTP/1.1 1010 ");
      end
      send_crlf();
      for (int i = 0; i < filler; i++) begin
         case ($urandom_range(0, 7))
            0:       c = CR;
            1:       c = LF;
            2:       c = " ";
            3:       c = "1";
            default: c = 8'($urandom_range(8'h21, 8'h7E));
         endcase
         send_data(c);
      end
      send_crlf();
      send_crlf();
   endtask

   task automatic send_frame(input logic fin, input logic [3:0] opc, input logic [15:0] len,
                             input logic masked, input logic ext16);
      logic [31:0] key;
      key = $urandom;
      // reserved bits are random; the block must not care
      send_data({fin, 3'($urandom_range(0, 7)), opc});
      if (ext16 || len > 16'd125) begin
         send_data({masked, LEN_EXT16});
         send_data(len[15:8]);
         send_data(len[7:0]);
      end else begin
         send_data({masked, len[6:0]});
      end
      if (masked)
         for (int i = 0; i < 4; i++)
            send_data(key[31 - 8 * i -: 8]);
      for (int i = 0; i < int'(len); i++)
         send_data(8'($urandom));
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   // Limit of one: the second handshake byte overruns it; later bytes are dropped.
   task automatic test_limit_overrun();
      write_limit(16'd1);
      send_data(" ");
      send_data("1");
      send_data(8'hFF);
      send_restart();
   endtask

   // Terminator with no status text in front of it closes the link.
   task automatic test_missing_status();
      wait_idle();
      write_limit(16'hFFFF);
      send_crlf();
      send_crlf();
      send_restart();
   endtask

   // Minimal good handshake, an empty final text frame, then the 64-bit length code.
   task automatic test_header_corners();
      send_string(" 101 ");
      send_crlf();
      send_crlf();
      send_data({1'b1, 3'b000, OPC_TEXT});
      send_data(8'h00);
      send_data({1'b0, 3'b000, OPC_TEXT});
      send_data({1'b1, LEN_EXT64});
      send_restart();
   endtask

   // Hold the result channel long enough that the input must stall, then let the
   // sender wait for every result before moving on.
   task automatic test_backpressure();
      wait_idle();
      req_gap_max = 0;
      rsp_gap_max = 0;
      send_restart();
      send_upgrade_reply(1'b1);
      hold_cycles = 120;
      send_frame(1'b1, OPC_TEXT, 16'd60, 1'b1, 1'b0);
      send_frame(1'b1, OPC_PING, 16'd20, 1'b0, 1'b1);
      wait_idle();
      req_gap_max = 15;
      rsp_gap_max = 15;
   endtask

   // Connection sessions: mostly well-formed handshakes and frames with random content,
   // with some bad handshakes, noise, truncated headers and traffic after close.
   task automatic test_random_sessions();
      int unsigned stop_at;
      int unsigned session;
      int unsigned pick;
      int unsigned nframes;
      logic        alive;
      logic        fin;
      logic        masked;
      logic        ext16;
      logic [3:0]  opc;
      logic [15:0] len;
      stop_at = sent_items + RANDOM_ITEMS;
      session = 0;
      while (sent_items < stop_at) begin
         // move to a new limit setting every few sessions, only once idle
         if (session % 3 == 0) begin
            wait_idle();
            case ((session / 3) % 5)
               0:       write_limit(16'hFFFF);
               1:       write_limit(16'($urandom_range(20, 60)));
               2:       write_limit(16'd1);
               3:       write_limit(LIMIT_RESET);
               default: write_limit(16'($urandom_range(61, 400)));
            endcase
         end
         req_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
         rsp_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
         send_restart();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_upgrade_reply(1'b0);
         end else if (pick < 14) begin
            repeat ($urandom_range(1, 30)) send_data(8'($urandom));
         end else begin
            send_upgrade_reply(1'b1);
         end
         alive   = (link.phase == PH_BYTE0);
         nframes = $urandom_range(1, 8);
         for (int f = 0; f < nframes && alive; f++) begin
            pick   = $urandom_range(0, 99);
            fin    = ($urandom_range(0, 3) != 0);
            masked = 1'($urandom_range(0, 1));
            if (pick < 5) begin
               // cut a header short; the next restart recovers
               send_data({fin, 3'($urandom_range(0, 7)), 4'($urandom)});
               send_data({1'b1, 7'($urandom_range(0, 125))});
               repeat ($urandom_range(0, 3)) send_data(8'($urandom));
               alive = 1'b0;
            end else if (pick < 10) begin
               send_data({fin, 3'($urandom_range(0, 7)), 4'($urandom)});
               send_data({masked, LEN_EXT64});
            end else begin
               pick = $urandom_range(0, 99);
               if (pick < 55)
                  opc = ($urandom_range(0, 1) != 0) ? OPC_TEXT : OPC_CONT;
               else if (pick < 75)
                  opc = OPC_PING;
               else if (pick < 85)
                  opc = OPC_CLOSE;
               else
                  opc = 4'($urandom_range(0, 15));
               pick = $urandom_range(0, 99);
               if (pick < 15)
                  len = 16'd0;
               else if (pick < 70)
                  len = 16'($urandom_range(1, 10));
               else if (pick < 90)
                  len = 16'($urandom_range(11, 125));
               else
                  len = 16'($urandom_range(126, 300));
               ext16 = (len > 16'd125) || ($urandom_range(0, 9) == 0);
               send_frame(fin, opc, len, masked, ext16);
            end
            if (link.phase == PH_CLOSED)
               alive = 1'b0;
         end
         // poke a closed link with a few more bytes now and then
         if (link.phase == PH_CLOSED && $urandom_range(0, 1) != 0)
            repeat ($urandom_range(1, 3)) send_data(8'($urandom));
         session++;
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset         <= 1'b0;
      link          = STATE_RESET;
      limit_setting = LIMIT_RESET;

      test_limit_overrun();
      test_missing_status();
      test_header_corners();
      test_backpressure();
      test_random_sessions();

      wait_idle();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_events.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         if (expected_events.size() != 0)
            $error("%0d expected results never arrived", expected_events.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
